// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/stk_pkg.sv =====
// ---------------------------------------------------------------------------
// stk_pkg
// shared constants, types and helpers of the semitone transition key detector
// ---------------------------------------------------------------------------
package stk_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int PITCH_W         = 7;
   localparam int CLASSES         = 12;
   localparam int CLASS_W         = 4;
   localparam int KEYS            = 15;
   localparam int KEY_SLOTS       = 16;
   localparam int KEY_W           = 4;
   localparam int FIFTHS_W        = 4;
   localparam int BEST_W          = 17;
   localparam int RANK_W          = 4;

   // pitch mod 12 by reciprocal: q = (p * 43) >> 9 is exact for 7-bit p
   localparam int MOD12_RECIP = 43;
   localparam int MOD12_SHIFT = 9;
   localparam int PROD_W      = 13;

   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [KEY_W-1:0]   key_idx_type;
   typedef logic [RANK_W-1:0]  rank_type;

   // key index 0..14 maps to fifths -7..7: add 9 modulo 16
   localparam key_idx_type FIFTHS_OFFSET = 4'd9;

   // bins scored per key, from -7 fifths up to +7 fifths
   localparam class_type KEY_BIN_A [KEYS] =
      '{4'd3, 4'd10, 4'd5, 4'd0, 4'd7, 4'd2, 4'd9, 4'd4,
        4'd11, 4'd6, 4'd1, 4'd8, 4'd3, 4'd10, 4'd5};
   localparam class_type KEY_BIN_B [KEYS] =
      '{4'd10, 4'd5, 4'd0, 4'd7, 4'd2, 4'd9, 4'd4, 4'd11,
        4'd6, 4'd1, 4'd8, 4'd3, 4'd10, 4'd5, 4'd0};

   // tie order: 2*|fifths| plus one for sharps, lower wins
   localparam rank_type KEY_RANK [KEYS] =
      '{4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0,
        4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd15};

   typedef struct packed {
      logic      hit;
      class_type cls;
      logic      last;
   } pair_dec_type;

   function automatic class_type pitch_class(input logic [PITCH_W-1:0] p);
      logic [PROD_W-1:0] prod;
      logic [3:0]        q;
      logic [7:0]        r;
      prod = PROD_W'(p) * PROD_W'(MOD12_RECIP);
      q    = prod[PROD_W-1:MOD12_SHIFT];
      r    = {1'b0, p} - (8'(q) * 8'(CLASSES));
      return r[CLASS_W-1:0];
   endfunction

endpackage

// ===== rtl/core/semitone_transition_key_detector.sv =====
// ---------------------------------------------------------------------------
// semitone_transition_key_detector
// key signature estimate from semitone steps between consecutive chords
// ---------------------------------------------------------------------------
// each input beat carries one note pair from two consecutive chords; a pair
// one semitone apart bumps the saturating bin of the lower pitch's class. a
// beat with last_pair set closes the piece: its own pair is counted, the 15
// key signatures (-7..7 fifths) are scored as the sum of two bins each, the
// best key goes out with its score (ties go to fewer accidentals, then to the
// flat key) and the histogram starts over from zero. the block takes one beat
// per clock; a key result passes through the snapshot register and then the
// result register. the input stalls only while a scored snapshot is waiting
// behind a stalled result
// ---------------------------------------------------------------------------
module semitone_transition_key_detector #(
   parameter int COUNT_WIDTH = stk_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pair beats
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [stk_pkg::PITCH_W-1:0]         req_pitch_a,
   input  logic [stk_pkg::PITCH_W-1:0]         req_pitch_b,
   input  logic                                req_pair_valid,
   input  logic                                req_last_pair,
   // key beats
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [stk_pkg::FIFTHS_W-1:0] rsp_key_fifths,
   output logic [stk_pkg::BEST_W-1:0]          rsp_best_score
);

   stk_pkg::pair_dec_type    dec;
   logic [stk_pkg::PITCH_W-1:0] pitch_lo;
   logic                     semitone;
   logic                     take;
   logic                     snap_valid;
   logic [COUNT_WIDTH-1:0]   snap_counts [stk_pkg::CLASSES];

   // pair decode: one semitone apart, checked one bit wider so 0 vs 127 is no step
   assign pitch_lo = (req_pitch_a < req_pitch_b) ? req_pitch_a : req_pitch_b;
   assign semitone = ({1'b0, req_pitch_a} == ({1'b0, req_pitch_b} + 8'd1)) ||
                     ({1'b0, req_pitch_b} == ({1'b0, req_pitch_a} + 8'd1));

   always_comb begin
      dec.hit  = req_pair_valid && semitone;
      dec.cls  = stk_pkg::pitch_class(pitch_lo);
      dec.last = req_last_pair;
   end

   // histogram, snapshot taken on the closing beat
   stk_bins #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_bins (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .dec         (dec),
      .take        (take),
      .snap_valid  (snap_valid),
      .snap_counts (snap_counts)
   );

   // key scores, selection and result register
   stk_score #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_score (
      .clock          (clock),
      .reset          (reset),
      .snap_valid     (snap_valid),
      .snap_counts    (snap_counts),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_fifths (rsp_key_fifths),
      .rsp_best_score (rsp_best_score)
   );

endmodule

// ===== rtl/core/stk_bins.sv =====
// ---------------------------------------------------------------------------
// stk_bins
// pitch class histogram with saturating bins and snapshot on the last beat
// ---------------------------------------------------------------------------
module stk_bins #(
   parameter int COUNT_WIDTH = stk_pkg::COUNT_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  stk_pkg::pair_dec_type    dec,
   input  logic                     take,
   output logic                     snap_valid,
   output logic [COUNT_WIDTH-1:0]   snap_counts [stk_pkg::CLASSES]
);

   logic [COUNT_WIDTH-1:0] count_ff  [stk_pkg::CLASSES];
   logic [COUNT_WIDTH-1:0] count_in  [stk_pkg::CLASSES];
   logic [COUNT_WIDTH-1:0] count_upd [stk_pkg::CLASSES];
   logic [COUNT_WIDTH-1:0] snap_ff   [stk_pkg::CLASSES];
   logic                   snap_valid_ff;
   logic                   snap_valid_in;
   logic                   accept;

   // a waiting snapshot blocks the channel only while it cannot move on
   assign req_stall = snap_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int i = 0; i < stk_pkg::CLASSES; i++) begin
         logic inc;
         inc = dec.hit && (dec.cls == stk_pkg::CLASS_W'(i)) && (count_ff[i] != '1);
         count_upd[i] = count_ff[i] + COUNT_WIDTH'(inc);
         if (accept) begin
            count_in[i] = dec.last ? '0 : count_upd[i];
         end else begin
            count_in[i] = count_ff[i];
         end
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (accept && dec.last) begin
         snap_valid_in = 1'b1;
      end else if (take) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         for (int i = 0; i < stk_pkg::CLASSES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         snap_valid_ff <= snap_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && dec.last) begin
         snap_ff <= count_upd;
      end
   end

   assign snap_valid  = snap_valid_ff;
   assign snap_counts = snap_ff;

endmodule

// ===== rtl/core/stk_score.sv =====
// ---------------------------------------------------------------------------
// stk_score
// key scoring, tie-ordered selection tree and result register
// ---------------------------------------------------------------------------
module stk_score #(
   parameter int COUNT_WIDTH = stk_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              snap_valid,
   input  logic [COUNT_WIDTH-1:0]            snap_counts [stk_pkg::CLASSES],
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [stk_pkg::FIFTHS_W-1:0] rsp_key_fifths,
   output logic [stk_pkg::BEST_W-1:0]        rsp_best_score
);

   localparam int SW = COUNT_WIDTH + 1;

   logic [SW-1:0]            sc0 [stk_pkg::KEY_SLOTS];
   stk_pkg::key_idx_type     kx0 [stk_pkg::KEY_SLOTS];
   logic [SW-1:0]            sc1 [8];
   stk_pkg::key_idx_type     kx1 [8];
   logic [SW-1:0]            sc2 [4];
   stk_pkg::key_idx_type     kx2 [4];
   logic [SW-1:0]            sc3 [2];
   stk_pkg::key_idx_type     kx3 [2];
   logic [SW-1:0]            win_score;
   stk_pkg::key_idx_type     win_key;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [SW-1:0]            score_ff;
   stk_pkg::key_idx_type     key_ff;

   // true when candidate a beats candidate b
   function automatic logic pick_a(input logic [SW-1:0] sa, input stk_pkg::key_idx_type ka,
                                   input logic [SW-1:0] sb, input stk_pkg::key_idx_type kb);
      return (sa > sb) ||
             ((sa == sb) && (stk_pkg::KEY_RANK[ka] < stk_pkg::KEY_RANK[kb]));
   endfunction

   always_comb begin
      for (int i = 0; i < stk_pkg::KEYS; i++) begin
         sc0[i] = {1'b0, snap_counts[stk_pkg::KEY_BIN_A[i]]} +
                  {1'b0, snap_counts[stk_pkg::KEY_BIN_B[i]]};
         kx0[i] = stk_pkg::KEY_W'(i);
      end
      // spare slot repeats the last key so it never changes the outcome
      sc0[stk_pkg::KEY_SLOTS-1] = sc0[stk_pkg::KEYS-1];
      kx0[stk_pkg::KEY_SLOTS-1] = kx0[stk_pkg::KEYS-1];

      for (int i = 0; i < 8; i++) begin
         if (pick_a(sc0[2*i], kx0[2*i], sc0[2*i+1], kx0[2*i+1])) begin
            sc1[i] = sc0[2*i];
            kx1[i] = kx0[2*i];
         end else begin
            sc1[i] = sc0[2*i+1];
            kx1[i] = kx0[2*i+1];
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (pick_a(sc1[2*i], kx1[2*i], sc1[2*i+1], kx1[2*i+1])) begin
            sc2[i] = sc1[2*i];
            kx2[i] = kx1[2*i];
         end else begin
            sc2[i] = sc1[2*i+1];
            kx2[i] = kx1[2*i+1];
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (pick_a(sc2[2*i], kx2[2*i], sc2[2*i+1], kx2[2*i+1])) begin
            sc3[i] = sc2[2*i];
            kx3[i] = kx2[2*i];
         end else begin
            sc3[i] = sc2[2*i+1];
            kx3[i] = kx2[2*i+1];
         end
      end
      if (pick_a(sc3[0], kx3[0], sc3[1], kx3[1])) begin
         win_score = sc3[0];
         win_key   = kx3[0];
      end else begin
         win_score = sc3[1];
         win_key   = kx3[1];
      end
   end

   assign take = snap_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         score_ff <= win_score;
         key_ff   <= win_key + stk_pkg::FIFTHS_OFFSET;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_fifths = $signed(key_ff);

   generate
      if (SW >= stk_pkg::BEST_W) begin : g_trunc
         assign rsp_best_score = score_ff[stk_pkg::BEST_W-1:0];
      end else begin : g_ext
         assign rsp_best_score = {{(stk_pkg::BEST_W-SW){1'b0}}, score_ff};
      end
   endgenerate

endmodule

// ===== rtl/core/stk_checker.sv =====
// ---------------------------------------------------------------------------
// stk_checker
// port-level checks of the semitone transition key detector
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [stk_pkg::PITCH_W-1:0]         req_pitch_a,
   input logic [stk_pkg::PITCH_W-1:0]         req_pitch_b,
   input logic                                req_pair_valid,
   input logic                                req_last_pair,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [stk_pkg::FIFTHS_W-1:0] rsp_key_fifths,
   input logic [stk_pkg::BEST_W-1:0]          rsp_best_score
);

   logic last_beat;
   logic pair_seen;

   assign last_beat = req_valid && !req_stall && req_last_pair;
   // pair fields only matter on a beat, folded here to keep them observed
   assign pair_seen = req_pair_valid && (req_pitch_a != req_pitch_b);

   // no result right after reset
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // a closing beat always yields a key once it has passed the snapshot and result registers
   `ASSERT_NEXT(a_last_yields_key, clock, reset, last_beat, ##1 rsp_valid)

   // the key never leaves -7..7
   `ASSERT_IMPLIES(a_key_range, clock, reset, rsp_valid || pair_seen,
      !rsp_valid || (rsp_key_fifths != 4'sb1000))

   // a stalled key beat holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_key_fifths) && $stable(rsp_best_score))

endmodule

bind semitone_transition_key_detector stk_checker u_stk_checker (.*);

// ===== sim/semitone_transition_key_detector_tb.sv =====
// ---------------------------------------------------------------------------
// semitone_transition_key_detector_tb
// self-checking bench for the semitone transition key detector
// ---------------------------------------------------------------------------
// a table of hand-picked pair beats runs first: empty piece after reset,
// pitch extremes, ignored flush beats, the flat-over-sharp tie, the
// fewer-accidentals tie, a last beat that also carries a pair, and two bins
// built up to large counts. random pieces follow under several idle and stall
// mixes plus one long output hold-off. every key beat is checked against the
// expected key of a typed row, else a local histogram model of the block
// ---------------------------------------------------------------------------
module semitone_transition_key_detector_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_W     = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int STUCK_LIMIT = 4000;
   localparam int MAX_REPORTS = 10;

   // one pair beat of the stimulus; typed rows carry their own expected key
   typedef struct packed {
      logic [6:0]        a;
      logic [6:0]        b;
      logic              pv;
      logic              last;
      logic [16:0]       reps;
      logic              typed;
      logic signed [3:0] fifths;
      logic [16:0]       score;
   } pair_beat_type;

   typedef struct packed {
      logic signed [3:0] fifths;
      logic [16:0]       score;
   } key_result_type;

   // bins scored per key, from -7 fifths up to +7 fifths
   localparam int SCALE_BIN_LO [15] = '{3, 10, 5, 0, 7, 2, 9, 4, 11, 6, 1, 8, 3, 10, 5};
   localparam int SCALE_BIN_HI [15] = '{10, 5, 0, 7, 2, 9, 4, 11, 6, 1, 8, 3, 10, 5, 0};

   // directed stimulus: a, b, pair_valid, last_pair, repeat, typed, key, score
   localparam int N_DIRECTED = 20;
   localparam pair_beat_type DIRECTED [N_DIRECTED] = '{
      // empty piece straight out of reset gives C with nothing scored
      '{7'd0,   7'd0,   1'b0, 1'b1, 17'd1,     1'b1, 4'sd0,  17'd0},
      // pitch extremes, unison and wide leaps
      '{7'd0,   7'd1,   1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd127, 7'd126, 1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd127, 7'd127, 1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd0,   7'd127, 1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      // semitone on a flush-only beat must not count
      '{7'd5,   7'd4,   1'b0, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      // last beat that still carries a pair
      '{7'd64,  7'd65,  1'b1, 1'b1, 17'd1,     1'b0, 4'sd0,  17'd0},
      // histogram cleared, all-ones pitch ignored on a flush
      '{7'd127, 7'd0,   1'b0, 1'b1, 17'd1,     1'b1, 4'sd0,  17'd0},
      // bins 10 and 5: six flats and six sharps tie, flats win
      '{7'd10,  7'd11,  1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd6,   7'd5,   1'b1, 1'b1, 17'd1,     1'b1, -4'sd6, 17'd2},
      // bins 3 and 10: five sharps beat seven flats
      '{7'd3,   7'd4,   1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd22,  7'd23,  1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd0,   7'd0,   1'b0, 1'b1, 17'd1,     1'b1, 4'sd5,  17'd2},
      // top-octave classes
      '{7'd11,  7'd12,  1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd118, 7'd119, 1'b1, 1'b0, 17'd1,     1'b0, 4'sd0,  17'd0},
      '{7'd126, 7'd127, 1'b1, 1'b1, 17'd1,     1'b0, 4'sd0,  17'd0},
      // bins 0 and 7 built up to large counts
      '{7'd60,  7'd61,  1'b1, 1'b0, 17'd40,    1'b0, 4'sd0,  17'd0},
      '{7'd67,  7'd68,  1'b1, 1'b0, 17'd40,    1'b0, 4'sd0,  17'd0},
      '{7'd61,  7'd60,  1'b1, 1'b1, 17'd1,     1'b1, -4'sd4, 17'd81},
      // large bins cleared again
      '{7'd0,   7'd0,   1'b0, 1'b1, 17'd1,     1'b1, 4'sd0,  17'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [6:0]        req_pitch_a = '0;
   logic [6:0]        req_pitch_b = '0;
   logic              req_pair_valid = 1'b0;
   logic              req_last_pair = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [3:0] rsp_key_fifths;
   logic [16:0]       rsp_best_score;

   // local copy of the transition histogram
   logic [COUNT_W-1:0] class_hist [12] = '{default: '0};
   key_result_type     pending_keys [$];

   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   bit hold_pending  = 1'b0;
   int favored [2]   = '{0, 7};

   int mismatch_count     = 0;
   int beats_sent         = 0;
   int keys_checked       = 0;
   int holds_done         = 0;
   int input_stall_cycles = 0;
   int stuck_cycles       = 0;

   semitone_transition_key_detector #(
      .COUNT_WIDTH(COUNT_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pitch_a    (req_pitch_a),
      .req_pitch_b    (req_pitch_b),
      .req_pair_valid (req_pair_valid),
      .req_last_pair  (req_last_pair),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_fifths (rsp_key_fifths),
      .rsp_best_score (rsp_best_score)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // histogram update for one pair beat; on a last beat, score all keys and clear
   function automatic void count_and_score(input pair_beat_type beat, output logic emit,
                                           output key_result_type key);
      logic [6:0]  lo;
      logic [6:0]  hi;
      logic [16:0] sum;
      int          cls;
      int          k;
      int          k_abs;
      int          best_abs;
      emit = 1'b0;
      key  = '0;
      if (beat.pv) begin
         lo = (beat.a < beat.b) ? beat.a : beat.b;
         hi = (beat.a < beat.b) ? beat.b : beat.a;
         if (hi - lo == 7'd1) begin
            cls = int'(lo) % 12;
            if (class_hist[cls] != {COUNT_W{1'b1}})
               class_hist[cls] = class_hist[cls] + 1'b1;
         end
      end
      if (beat.last) begin
         emit     = 1'b1;
         best_abs = 0;
         for (int i = 0; i < 15; i++) begin
            k     = i - 7;
            k_abs = (k < 0) ? -k : k;
            sum   = 17'(class_hist[SCALE_BIN_LO[i]]) + 17'(class_hist[SCALE_BIN_HI[i]]);
            // flats come first, so a strict compare keeps the flat key on a full tie
            if (i == 0 || sum > key.score || (sum == key.score && k_abs < best_abs)) begin
               key.score  = sum;
               key.fifths = 4'(k);
               best_abs   = k_abs;
            end
         end
         for (int i = 0; i < 12; i++)
            class_hist[i] = '0;
      end
   endfunction

   // random pair beat: mostly semitone steps, many on the piece's favored classes
   function automatic pair_beat_type random_beat(input int last_odds);
      pair_beat_type beat;
      int            lo;
      int            cls;
      beat      = '0;
      beat.reps = 17'd1;
      beat.pv   = ($urandom_range(9) != 0);
      beat.last = ($urandom_range(last_odds - 1) == 0);
      case ($urandom_range(3))
         0: begin
            lo = -1;
            beat.a = 7'($urandom_range(127));
            beat.b = 7'($urandom_range(127));
         end
         1: lo = $urandom_range(126);
         default: begin
            cls = favored[$urandom_range(1)];
            lo  = cls + 12 * $urandom_range((126 - cls) / 12);
         end
      endcase
      if (lo >= 0) begin
         if ($urandom_range(1)) begin
            beat.a = 7'(lo);
            beat.b = 7'(lo + 1);
         end else begin
            beat.a = 7'(lo + 1);
            beat.b = 7'(lo);
         end
      end
      if (beat.last) begin
         favored[0] = $urandom_range(11);
         favored[1] = $urandom_range(11);
      end
      return beat;
   endfunction

   // offer one beat, hold it until accepted, then update the model
   task automatic send_beat(input pair_beat_type beat);
      logic           emit;
      key_result_type key;
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_valid      <= 1'b1;
      req_pitch_a    <= beat.a;
      req_pitch_b    <= beat.b;
      req_pair_valid <= beat.pv;
      req_last_pair  <= beat.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      count_and_score(beat, emit, key);
      if (emit) begin
         if (beat.typed) begin
            key.fifths = beat.fifths;
            key.score  = beat.score;
         end
         pending_keys.push_back(key);
      end
   endtask

   // sender goes quiet until every expected key has come back
   task automatic drain_keys;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_keys.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int n_beats,
                            input int last_odds);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (n_beats) send_beat(random_beat(last_odds));
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch: %s", msg);
   endtask

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // key beat checker
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_keys.size() == 0) begin
            report_mismatch($sformatf("unexpected key beat fifths %0d score %0d",
                                      rsp_key_fifths, rsp_best_score));
         end else begin
            want = pending_keys.pop_front();
            keys_checked++;
            if (rsp_key_fifths !== want.fifths || rsp_best_score !== want.score)
               report_mismatch($sformatf("key %0d: fifths %0d score %0d, expected %0d / %0d",
                                         keys_checked, rsp_key_fifths, rsp_best_score,
                                         want.fifths, want.score));
         end
      end
   end

   // watchdog on cycles where neither channel moves a beat
   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (req_valid && req_stall)
            input_stall_cycles++;
      end
      $display("watchdog: no beat moved for %0d cycles, %0d keys still expected",
               STUCK_LIMIT, pending_keys.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (DIRECTED[i])
         repeat (DIRECTED[i].reps) send_beat(DIRECTED[i]);
      drain_keys();

      // random pieces under each idle mix
      run_phase(0, 0, 380, 15);
      drain_keys();
      run_phase(52, 0, 380, 15);
      drain_keys();
      run_phase(0, 52, 380, 15);
      drain_keys();
      run_phase(15, 15, 380, 15);
      drain_keys();

      // output held off while short pieces keep coming, so the input backs up
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_pending  = 1'b1;
      run_phase(0, 0, 300, 3);
      drain_keys();

      // result path is two registers deep, so the bench idles before the summary
      repeat (8) @(posedge clock);

      $display("sent %0d pair beats and checked %0d key beats, %0d mismatches",
               beats_sent, keys_checked, mismatch_count);
      $display("covered ties, large bins, flush beats, %0d output hold-offs, %0d input stalls",
               holds_done, input_stall_cycles);
      if (mismatch_count == 0 && pending_keys.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
